// ----- sv/spp_pkg.sv -----
// Package for the spectrum peak picker: sample and field widths, default frame length.
package spp_pkg;

   // sample width of each complex component (fixed by the input fields)
   localparam int SAMPLE_BITS      = 16;
   // default longest frame in bins
   localparam int MAX_BINS_DEFAULT = 4096;

   // sum of squares and root widths
   localparam int SUM_W  = 2 * SAMPLE_BITS;
   localparam int ROOT_W = SAMPLE_BITS;
   localparam int REM_W  = ROOT_W + 2;

   // result field widths
   localparam int MAG_W   = 16;
   localparam int PBIN_W  = 12;
   localparam int ORD_W   = 11;
   localparam logic [ORD_W-1:0] ORD_MAX = '1;

   // packed stream widths
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

endpackage

// ----- sv/spectrum_peak_picker.sv -----
// Spectrum peak picker: magnitude by shared multiplier and bit-serial root, 3-point maxima.
// From acceptance to the result register each word passes through the shared
// multiplier (re squared, then im squared added), the bit-serial square root
// (two radicand bits per cycle) and a final step to decide and emit.
// req_tready is high only while the sequencer idles, so a new word is taken only after the last is done;
// the decide step waits while it has a result to emit and the previous result has not been taken.
// Synchronous active-high reset clears sequencer, output valid, magnitudes and bin and peak counters.
module spectrum_peak_picker #(
   parameter int MAX_BINS = spp_pkg::MAX_BINS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // req_tdata: real_part [15:0], imag_part [31:16]
   input  logic [spp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tlast,   // last_bin
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // rsp_tdata: peak_bin [11:0], peak_magnitude [27:12], peak_ordinal [38:28], zero [39]
   output logic [spp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tuser,   // peak_found
   output logic                          rsp_tlast,   // frame_end
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready
);

   localparam int SB     = spp_pkg::SAMPLE_BITS;
   localparam int SUM_W  = spp_pkg::SUM_W;
   localparam int ROOT_W = spp_pkg::ROOT_W;
   localparam int REM_W  = spp_pkg::REM_W;
   localparam int MAG_W  = spp_pkg::MAG_W;
   localparam int PBIN_W = spp_pkg::PBIN_W;
   localparam int ORD_W  = spp_pkg::ORD_W;
   localparam int BIN_W  = $clog2(MAX_BINS);
   localparam int EXT_W  = (BIN_W > PBIN_W) ? BIN_W : PBIN_W;
   localparam int ITER   = ROOT_W;
   localparam int CNT_W  = $clog2(ITER);
   localparam int PAD_W  = spp_pkg::RSP_DATA_W - PBIN_W - MAG_W - ORD_W;
   localparam logic [BIN_W-1:0] LAST_IDX = BIN_W'(MAX_BINS - 1);
   localparam logic [CNT_W-1:0] LAST_IT  = CNT_W'(ITER - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SQ_RE  = 5'b00010,
      ST_SQ_IM  = 5'b00100,
      ST_ROOT   = 5'b01000,
      ST_DECIDE = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic signed [SB-1:0]   re_ff, re_in;
   logic signed [SB-1:0]   im_ff, im_in;
   logic                   last_ff, last_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [MAG_W-1:0]       prev_ff, prev_in;
   logic [MAG_W-1:0]       older_ff, older_in;
   logic [BIN_W-1:0]       bin_ff, bin_in;
   logic [ORD_W-1:0]       peaks_ff, peaks_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_peak_ff, rsp_peak_in;
   logic                   rsp_end_ff, rsp_end_in;
   logic [PBIN_W-1:0]      rsp_bin_ff, rsp_bin_in;
   logic [MAG_W-1:0]       rsp_mag_ff, rsp_mag_in;
   logic [ORD_W-1:0]       rsp_ord_ff, rsp_ord_in;

   logic                   req_fire;
   logic signed [SB-1:0]   mul_op;
   logic signed [SUM_W-1:0] mul_prod;
   logic [REM_W-1:0]       rem_shift;
   logic [REM_W-1:0]       trial;
   logic                   trial_ok;
   logic [MAG_W-1:0]       mag;
   logic                   frame_end;
   logic                   is_peak;
   logic                   emit;
   logic                   out_free;
   logic [EXT_W-1:0]       idx_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // shared multiplier: squares one component per cycle
   assign mul_op   = (state_ff == ST_SQ_RE) ? re_ff : im_ff;
   assign mul_prod = mul_op * mul_op;

   // one root digit: bring down two radicand bits, try 4*root+1
   assign rem_shift = {rem_ff[REM_W-3:0], sum_ff[SUM_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign trial_ok  = (rem_shift >= trial);

   // root of a 2*SB bit sum of squares always fits the magnitude width
   assign mag = MAG_W'(root_ff);

   // peak and frame-end decision
   assign frame_end = last_ff || (bin_ff == LAST_IDX);
   assign is_peak   = (bin_ff >= BIN_W'(2)) && (prev_ff > older_ff) && (prev_ff > mag);
   assign emit      = is_peak || frame_end;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign idx_ext   = EXT_W'(is_peak ? (bin_ff - BIN_W'(1)) : bin_ff);

   always_comb begin
      state_in     = state_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      last_in      = last_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      prev_in      = prev_ff;
      older_in     = older_ff;
      bin_in       = bin_ff;
      peaks_in     = peaks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_peak_in  = rsp_peak_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_mag_in   = rsp_mag_ff;
      rsp_ord_in   = rsp_ord_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               re_in    = req_tdata[SB-1:0];
               im_in    = req_tdata[2*SB-1:SB];
               last_in  = req_tlast;
               state_in = ST_SQ_RE;
            end
         end
         ST_SQ_RE: begin
            sum_in   = $unsigned(mul_prod);
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            sum_in   = sum_ff + $unsigned(mul_prod);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rem_in  = trial_ok ? (rem_shift - trial) : rem_shift;
            root_in = {root_ff[ROOT_W-2:0], trial_ok};
            sum_in  = {sum_ff[SUM_W-3:0], 2'b00};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_IT) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!emit || out_free) begin
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_peak_in  = is_peak;
                  rsp_end_in   = frame_end;
                  rsp_bin_in   = idx_ext[PBIN_W-1:0];
                  rsp_mag_in   = is_peak ? prev_ff : '0;
                  rsp_ord_in   = peaks_ff;
               end
               if (frame_end) begin
                  prev_in  = '0;
                  older_in = '0;
                  bin_in   = '0;
                  peaks_in = '0;
               end else begin
                  older_in = prev_ff;
                  prev_in  = mag;
                  bin_in   = bin_ff + BIN_W'(1);
                  if (is_peak && (peaks_ff != spp_pkg::ORD_MAX)) begin
                     peaks_in = peaks_ff + ORD_W'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         older_ff     <= '0;
         bin_ff       <= '0;
         peaks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         older_ff     <= older_in;
         bin_ff       <= bin_in;
         peaks_ff     <= peaks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result word
   always_ff @(posedge clock) begin
      re_ff       <= re_in;
      im_ff       <= im_in;
      last_ff     <= last_in;
      sum_ff      <= sum_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      cnt_ff      <= cnt_in;
      rsp_peak_ff <= rsp_peak_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_mag_ff  <= rsp_mag_in;
      rsp_ord_ff  <= rsp_ord_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_peak_ff;
   assign rsp_tlast  = rsp_end_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_ord_ff, rsp_mag_ff, rsp_bin_ff};

   // every result word reports a peak, a frame end or both
   a_rsp_has_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_peak_ff || rsp_end_ff))
      else $error("result word with neither peak nor frame end");

   // a peak is strictly above a neighbour, so its magnitude cannot be zero
   a_peak_mag_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_peak_ff) |-> (rsp_mag_ff != '0))
      else $error("peak reported with zero magnitude");

   // frame end without a peak carries zero magnitude
   a_end_mag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_peak_ff) |-> (rsp_mag_ff == '0))
      else $error("non-peak result with nonzero magnitude");

   // an accepted word starts the multiplier sequence on the next cycle
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SQ_RE))
      else $error("accepted word did not start squaring");

   // the bin counter never passes the last allowed index
   a_bin_bound: assert property (@(posedge clock) disable iff (reset)
      bin_ff <= LAST_IDX)
      else $error("bin counter beyond frame limit");

endmodule

// ----- tb/sv/tb_spectrum_peak_picker.sv -----
// Testbench for spectrum_peak_picker: stream driver, result monitor and magnitude peak predictor.
module tb_spectrum_peak_picker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS      = spp_pkg::SAMPLE_BITS;
   localparam int MAX_BINS_DEFAULT = spp_pkg::MAX_BINS_DEFAULT;
   localparam int PBIN_W           = spp_pkg::PBIN_W;
   localparam int MAG_W            = spp_pkg::MAG_W;
   localparam int ORD_W            = spp_pkg::ORD_W;
   localparam int REQ_DATA_W       = spp_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W       = spp_pkg::RSP_DATA_W;
   localparam logic [ORD_W-1:0] ORD_MAX = spp_pkg::ORD_MAX;

   localparam int FRAME_BINS   = MAX_BINS_DEFAULT;
   localparam int RANDOM_BINS  = 1725;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int DRAIN_CYCLES = 60;

   // one complex bin as sent on the request stream
   typedef struct {
      logic signed [SAMPLE_BITS-1:0] re;
      logic signed [SAMPLE_BITS-1:0] im;
      logic                          last;
   } bin_word_type;

   // one peak or frame-end report
   typedef struct {
      logic              found;
      logic [PBIN_W-1:0] bin;
      logic [MAG_W-1:0]  mag;
      logic [ORD_W-1:0]  ordinal;
      logic              fend;
   } peak_report_type;

   typedef enum int {
      SHAPE_WIDE,
      SHAPE_NARROW,
      SHAPE_EXTREME
   } bin_shape_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   bin_word_type    bins_to_send[$];
   peak_report_type peak_reports_due[$];

   // predictor state
   logic [MAG_W-1:0] mag_prev;
   logic [MAG_W-1:0] mag_older;
   int               bin_idx;
   int               peaks_in_frame;

   int  err_count = 0;
   int  cycle_count = 0;
   bit  req_took = 1'b0;
   int  send_gap = 0;
   bit  send_calm = 1'b0;
   int  stall_left = 0;
   bit  stall_calm = 1'b0;

   spectrum_peak_picker #(.MAX_BINS(FRAME_BINS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #6 clock = ~clock;

   // floor square root, one result bit per pass from the top
   function automatic logic [MAG_W-1:0] isqrt32(input longint unsigned radicand);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root[MAG_W-1:0];
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int rand_component(input bin_shape_type shape);
      int pick;
      case (shape)
         SHAPE_NARROW: begin
            return int'($urandom_range(0, 16)) - 8;
         end
         SHAPE_EXTREME: begin
            pick = $urandom_range(0, 4);
            if (pick == 0) return -32768;
            if (pick == 1) return 32767;
            if (pick == 2) return -1;
            if (pick == 3) return 1;
            return 0;
         end
         default: begin
            return int'($urandom_range(0, 65535)) - 32768;
         end
      endcase
   endfunction

   task automatic add_bin(input int re, input int im, input bit last);
      bin_word_type w;
      w.re   = SAMPLE_BITS'(re);
      w.im   = SAMPLE_BITS'(im);
      w.last = last;
      bins_to_send.push_back(w);
   endtask

   // work out the report, if any, caused by one accepted bin
   task automatic track_bin(input logic signed [SAMPLE_BITS-1:0] re,
                            input logic signed [SAMPLE_BITS-1:0] im,
                            input logic last_flag);
      longint unsigned energy;
      logic [MAG_W-1:0] mag;
      bit is_peak;
      bit is_end;
      peak_report_type r;
      energy  = longint'(re) * longint'(re) + longint'(im) * longint'(im);
      mag     = isqrt32(energy);
      is_end  = last_flag || (bin_idx + 1 >= FRAME_BINS);
      is_peak = bin_idx >= 2 && mag_prev > mag_older && mag_prev > mag;
      if (is_peak || is_end) begin
         r.found   = is_peak;
         r.bin     = is_peak ? PBIN_W'(bin_idx - 1) : PBIN_W'(bin_idx);
         r.mag     = is_peak ? mag_prev : '0;
         r.ordinal = ORD_W'(peaks_in_frame);
         r.fend    = is_end;
         peak_reports_due.push_back(r);
      end
      if (is_peak && peaks_in_frame < int'(ORD_MAX)) peaks_in_frame++;
      if (is_end) begin
         mag_prev       = '0;
         mag_older      = '0;
         bin_idx        = 0;
         peaks_in_frame = 0;
      end else begin
         mag_older = mag_prev;
         mag_prev  = mag;
         bin_idx++;
      end
   endtask

   // request driver: new word only after the previous one was taken
   always @(negedge clock) begin
      bin_word_type w;
      logic next_valid;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!req_tvalid || req_took) begin
         next_valid = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (bins_to_send.size() > 0) begin
            w = bins_to_send.pop_front();
            req_tdata  <= {w.im, w.re};
            req_tlast  <= w.last;
            next_valid = 1'b1;
            if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
            send_gap = (send_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
         end
      end
      req_tvalid <= next_valid;
   end

   // result back-pressure, with calm stretches
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!stall_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      if ($urandom_range(0, 255) == 0) stall_calm = !stall_calm;
   end

   // monitor: predict on accepted bins, check accepted reports
   always @(posedge clock) begin
      peak_report_type want;
      logic [PBIN_W-1:0] got_bin;
      logic [MAG_W-1:0]  got_mag;
      logic [ORD_W-1:0]  got_ord;
      cycle_count++;
      req_took = !reset && req_tvalid && req_tready;
      if (req_took)
         track_bin(req_tdata[SAMPLE_BITS-1:0], req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], req_tlast);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_bin = rsp_tdata[PBIN_W-1:0];
         got_mag = rsp_tdata[PBIN_W+MAG_W-1:PBIN_W];
         got_ord = rsp_tdata[PBIN_W+MAG_W+ORD_W-1:PBIN_W+MAG_W];
         if (peak_reports_due.size() == 0) begin
            $error("unexpected result word: bin %0d mag %0d", got_bin, got_mag);
            err_count++;
         end else begin
            want = peak_reports_due.pop_front();
            if (rsp_tuser !== want.found) begin
               $error("peak_found: expected %0d, got %0d", want.found, rsp_tuser);
               err_count++;
            end
            if (got_bin !== want.bin) begin
               $error("peak_bin: expected %0d, got %0d", want.bin, got_bin);
               err_count++;
            end
            if (got_mag !== want.mag) begin
               $error("peak_magnitude: expected %0d, got %0d", want.mag, got_mag);
               err_count++;
            end
            if (got_ord !== want.ordinal) begin
               $error("peak_ordinal: expected %0d, got %0d", want.ordinal, got_ord);
               err_count++;
            end
            if (rsp_tlast !== want.fend) begin
               $error("frame_end: expected %0d, got %0d", want.fend, rsp_tlast);
               err_count++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int sent;
      int len;
      bin_shape_type shape;
      mag_prev       = '0;
      mag_older      = '0;
      bin_idx        = 0;
      peaks_in_frame = 0;

      // single-bin frame at the most negative corner
      add_bin(-32768, -32768, 1'b1);
      // two bins: too short for any peak
      add_bin(32767, 32767, 1'b0);
      add_bin(0, 0, 1'b1);
      // peak on the bin before last shares the frame-end word
      add_bin(0, 0, 1'b0);
      add_bin(-32768, 0, 1'b0);
      add_bin(5, 5, 1'b1);
      // plateaus, ties and the largest magnitude
      add_bin(3, 4, 1'b0);
      add_bin(5, 0, 1'b0);
      add_bin(0, 5, 1'b0);
      add_bin(0, -5, 1'b0);
      add_bin(100, 0, 1'b0);
      add_bin(-32768, -32768, 1'b0);
      add_bin(32767, -32768, 1'b0);
      add_bin(1, 1, 1'b0);
      add_bin(0, -32768, 1'b0);
      add_bin(7, 0, 1'b1);
      // several peaks, then a frame end without one
      add_bin(0, 0, 1'b0);
      add_bin(10, 0, 1'b0);
      add_bin(0, 0, 1'b0);
      add_bin(0, 20, 1'b0);
      add_bin(0, 0, 1'b0);
      add_bin(0, 0, 1'b0);
      add_bin(-1, 0, 1'b1);

      // random frames, mostly short
      sent = 0;
      while (sent < RANDOM_BINS) begin
         len   = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 40) : $urandom_range(41, 400);
         shape = bin_shape_type'($urandom_range(0, 2));
         for (int i = 0; i < len; i++)
            add_bin(rand_component(shape), rand_component(shape), i == len - 1);
         sent += len;
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (bins_to_send.size() != 0 || req_tvalid) @(posedge clock);
      while (peak_reports_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/spp_pkg.sv
sv/spectrum_peak_picker.sv
tb/sv/tb_spectrum_peak_picker.sv
